### hdl/bounded_key_value_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value table
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_KEY_VALUE_TABLE_MACROS_SVH
`define BOUNDED_KEY_VALUE_TABLE_MACROS_SVH

// check a property on every clock edge out of reset
`define BKVT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check that the consequent holds whenever the antecedent does
`define BKVT_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/bkvt_pkg.sv
// ----------------------------------------------------------------------------
// bkvt_pkg
// Shared widths, operation codes and interface types of the key/value table.
// ----------------------------------------------------------------------------
package bkvt_pkg;

  localparam int KeyBits      = 32;
  localparam int ValueBits    = 32;
  localparam int CountBits    = 9;
  localparam int PosBits      = 8;
  localparam int OpBits       = 3;
  localparam int DefaultDepth = 256;

  localparam logic [CountBits-1:0] CapacityReset = CountBits'(256);

  localparam logic [OpBits-1:0] OpInsert = 3'd0;
  localparam logic [OpBits-1:0] OpUpdate = 3'd1;
  localparam logic [OpBits-1:0] OpUpsert = 3'd2;
  localparam logic [OpBits-1:0] OpErase  = 3'd3;
  localparam logic [OpBits-1:0] OpLookup = 3'd4;
  localparam logic [OpBits-1:0] OpRead   = 3'd5;

  typedef struct packed {
    logic [OpBits-1:0]    operation;
    logic [KeyBits-1:0]   key_word;
    logic [ValueBits-1:0] value_word;
    logic [PosBits-1:0]   position;
  } req_t;

  typedef struct packed {
    logic                 success;
    logic [KeyBits-1:0]   found_key;
    logic [ValueBits-1:0] found_value;
    logic [CountBits-1:0] entry_count;
    logic                 is_empty;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift;
    logic write_ins;
    logic write_upd;
    logic dec;
    logic finish;
    logic ok;
    logic take_key;
    logic take_value;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OpBits-1:0] op;
    logic              hit;
    logic              miss;
    logic              room;
    logic              shift_done;
    logic              read_ok;
  } status_t;

endpackage

### hdl/bkvt_datapath.sv
// ----------------------------------------------------------------------------
// bkvt_datapath
// Key and value memories, capacity and occupancy, scan counter and result register.
// ----------------------------------------------------------------------------
`include "bounded_key_value_table_macros.svh"

module bkvt_datapath
  import bkvt_pkg::*;
#(
  parameter int TABLE_DEPTH = DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  req_t                 req_i,
  input  logic                 cfg_we_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 done_o,
  output rsp_t                 rsp_o
);

  localparam int AddrBits    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CountMax    = (1 << CountBits) - 1;
  localparam int DepthCapInt = (TABLE_DEPTH > CountMax) ? CountMax : TABLE_DEPTH;
  localparam logic [CountBits-1:0] DepthCap = CountBits'(DepthCapInt);

  logic [KeyBits-1:0]   key_mem [TABLE_DEPTH];
  logic [ValueBits-1:0] val_mem [TABLE_DEPTH];

  req_t                 req_q;
  logic [CountBits-1:0] cap_q;
  logic [CountBits-1:0] occ_q, occ_d;
  logic [CountBits-1:0] scan_q, scan_d;
  logic                 pend_q, pend_d;
  logic [KeyBits-1:0]   rd_key_q;
  logic [ValueBits-1:0] rd_val_q;
  logic                 done_q;
  rsp_t                 rsp_q;

  logic [CountBits-1:0] cap_eff;
  logic                 hit, miss;
  logic                 key_we, val_we;
  logic [AddrBits-1:0]  waddr, raddr;
  logic [KeyBits-1:0]   key_wdata;
  logic [ValueBits-1:0] val_wdata;
  logic                 shift_wr;

  assign cap_eff  = (cap_q > DepthCap) ? DepthCap : cap_q;
  assign hit      = pend_q && (rd_key_q == req_q.key_word);
  assign miss     = !hit && (scan_q >= occ_q);
  assign shift_wr = cmd_i.shift && pend_q;

  assign status_o.op         = req_q.operation;
  assign status_o.hit        = hit;
  assign status_o.miss       = miss;
  assign status_o.room       = occ_q < cap_eff;
  assign status_o.shift_done = scan_q >= occ_q;
  assign status_o.read_ok    = scan_q < occ_q;

  // scan counter serves the search, the erase shift and the indexed read
  always_comb begin
    scan_d = scan_q;
    pend_d = pend_q;
    if (cmd_i.load) begin
      scan_d = (req_i.operation == OpRead) ? CountBits'(req_i.position) : '0;
      pend_d = 1'b0;
    end else if (cmd_i.scan) begin
      if (hit) begin
        pend_d = 1'b0;
      end else if (!miss) begin
        scan_d = scan_q + CountBits'(1);
        pend_d = 1'b1;
      end
    end else if (cmd_i.shift) begin
      if (scan_q < occ_q) begin
        scan_d = scan_q + CountBits'(1);
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.write_ins) begin
      occ_d = occ_q + CountBits'(1);
    end else if (cmd_i.dec) begin
      occ_d = occ_q - CountBits'(1);
    end
  end

  // one write port: append, overwrite at the hit, or move an entry down
  always_comb begin
    key_we    = cmd_i.write_ins || shift_wr;
    val_we    = cmd_i.write_ins || cmd_i.write_upd || shift_wr;
    key_wdata = shift_wr ? rd_key_q : req_q.key_word;
    val_wdata = shift_wr ? rd_val_q : req_q.value_word;
    priority if (cmd_i.write_ins) begin
      waddr = AddrBits'(occ_q);
    end else if (cmd_i.write_upd) begin
      waddr = AddrBits'(scan_q - CountBits'(1));
    end else begin
      waddr = AddrBits'(scan_q - CountBits'(2));
    end
  end

  assign raddr = AddrBits'(scan_q);

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[waddr] <= val_wdata;
    end
    rd_key_q <= key_mem[raddr];
    rd_val_q <= val_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapacityReset;
      occ_q  <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      occ_q  <= occ_d;
      scan_q <= scan_d;
      pend_q <= pend_d;
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.finish) begin
      rsp_q.success     <= cmd_i.ok;
      rsp_q.found_key   <= cmd_i.take_key ? rd_key_q : req_q.key_word;
      rsp_q.found_value <= cmd_i.take_value ? rd_val_q : '0;
      rsp_q.entry_count <= occ_d;
      rsp_q.is_empty    <= (occ_d == '0);
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `BKVT_CHECK(a_occ_bound, occ_q <= DepthCap, "occupancy beyond table depth")
  `BKVT_CHECK_IMPL(a_insert_room, cmd_i.write_ins, occ_q < cap_eff, "append without room")
  `BKVT_CHECK(a_done_follows, cmd_i.finish |=> done_q, "result strobe missing")
  `BKVT_CHECK_IMPL(a_shift_dest, shift_wr, scan_q >= CountBits'(2), "shift below entry zero")

endmodule

### hdl/bkvt_ctrl.sv
// ----------------------------------------------------------------------------
// bkvt_ctrl
// Sequencer: dispatch, linear key search, erase shift, indexed read and result issue.
// ----------------------------------------------------------------------------
module bkvt_ctrl
  import bkvt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SEARCH   = 5'b00100,
    S_SHIFT    = 5'b01000,
    S_READ     = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.op)
          OpRead: begin
            state_d = S_READ;
          end
          OpInsert, OpUpdate, OpUpsert, OpErase, OpLookup: begin
            state_d = S_SEARCH;
          end
          default: begin
            // unknown code: report failure, touch nothing
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        cmd_o.finish     = 1'b1;
        cmd_o.ok         = status_i.read_ok;
        cmd_o.take_key   = status_i.read_ok;
        cmd_o.take_value = status_i.read_ok;
        state_d          = S_IDLE;
      end
      S_SEARCH: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          unique case (status_i.op)
            OpUpdate, OpUpsert: begin
              cmd_o.write_upd = 1'b1;
              cmd_o.finish    = 1'b1;
              cmd_o.ok        = 1'b1;
              state_d         = S_IDLE;
            end
            OpLookup: begin
              cmd_o.finish     = 1'b1;
              cmd_o.ok         = 1'b1;
              cmd_o.take_value = 1'b1;
              state_d          = S_IDLE;
            end
            OpErase: begin
              state_d = S_SHIFT;
            end
            default: begin
              // duplicate key on insert
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          endcase
        end else if (status_i.miss) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          if ((status_i.op == OpInsert || status_i.op == OpUpsert) && status_i.room) begin
            cmd_o.write_ins = 1'b1;
            cmd_o.ok        = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (status_i.shift_done) begin
          cmd_o.dec    = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.ok     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### hdl/bounded_key_value_table.sv
// ----------------------------------------------------------------------------
// bounded_key_value_table: unsorted key/value table with unique keys
// A new request is taken only while busy is low, so one request is in flight at a time;
// it is accepted once the controller is back in idle after issuing the previous result.
// Reset: table empty, capacity 256; memories are not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module bounded_key_value_table
  import bkvt_pkg::*;
#(
  parameter int TABLE_DEPTH = DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CountBits-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    busy_int;

  assign busy        = busy_int;
  assign cfg_ready_o = !busy_int;

  bkvt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_int)
  );

  bkvt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule
